FILE: rtl/core/igmpc_pkg.sv
// ---------------------------------------------------------------------------
// igmpc_pkg
// shared types and constants of the igmp header checker
// ---------------------------------------------------------------------------
`default_nettype none

package igmpc_pkg;

    // packet size limits and igmpv3 layout
    localparam int unsigned MAX_PACKET_BYTES    = 2048;
    localparam int unsigned QUERY_BYTES         = 12;
    localparam int unsigned REPORT_HEADER_BYTES = 8;
    localparam int unsigned RECORD_BYTES        = 8;

    // internal widths
    localparam int unsigned COUNT_W = 12;
    localparam int unsigned TOTAL_W = COUNT_W + 1;
    localparam int unsigned HDR_W   = 6;
    localparam int unsigned LIMIT_W = 24;

    localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

    // protocol and message codes
    localparam logic [7:0] IGMP_PROTO  = 8'd2;
    localparam logic [7:0] TYPE_QUERY  = 8'd17;
    localparam logic [7:0] TYPE_REPORT = 8'h22;

    // byte offsets
    localparam logic [COUNT_W-1:0] POS_PROTO   = 12'd9;
    localparam logic [COUNT_W-1:0] POS_PAYLOAD = 12'd20;
    localparam logic [COUNT_W-1:0] OFF_COUNT_HI = 12'd6;
    localparam logic [COUNT_W-1:0] OFF_COUNT_LO = 12'd7;

    // verdict codes
    localparam logic [2:0] VERDICT_OK        = 3'd0;
    localparam logic [2:0] VERDICT_NOT_IGMP  = 3'd1;
    localparam logic [2:0] VERDICT_BAD_TYPE  = 3'd2;
    localparam logic [2:0] VERDICT_TOO_LONG  = 3'd3;
    localparam logic [2:0] VERDICT_BAD_CSUM  = 3'd4;
    localparam logic [2:0] VERDICT_TRUNCATED = 3'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } in_word_t;

    typedef struct packed {
        logic       accept;
        logic [2:0] verdict_code;
    } out_word_t;

    // packet state as seen after the final byte
    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic [HDR_W-1:0]   header_bytes;
        logic               is_igmp;
        logic [7:0]         msg_type;
        logic [15:0]        rec_count;
        logic [15:0]        ones_sum;
    } pkt_summary_t;

endpackage

`default_nettype wire

FILE: rtl/core/igmpc_in_reg.sv
// ---------------------------------------------------------------------------
// igmpc_in_reg
// input register stage, holds one word until the parser consumes it
// ---------------------------------------------------------------------------
`default_nettype none

module igmpc_in_reg (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire igmpc_pkg::in_word_t s_data,
    input  wire logic              consume,
    output logic                   word_valid,
    output igmpc_pkg::in_word_t    word
);

    logic                in_valid_reg;
    logic                in_valid_next;
    igmpc_pkg::in_word_t in_word_reg;

    assign s_ready = !in_valid_reg || consume;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (consume) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_data;
        end
    end

    assign word_valid = in_valid_reg;
    assign word       = in_word_reg;

endmodule

`default_nettype wire

FILE: rtl/core/igmpc_parser.sv
// ---------------------------------------------------------------------------
// igmpc_parser
// per-packet header fields and running ones' complement payload sum
// ---------------------------------------------------------------------------
`default_nettype none

module igmpc_parser (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 consume,
    input  wire igmpc_pkg::in_word_t  word,
    output igmpc_pkg::pkt_summary_t   summary
);

    logic [igmpc_pkg::COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [igmpc_pkg::HDR_W-1:0]   header_bytes_reg, header_bytes_next;
    logic                          is_igmp_reg, is_igmp_next;
    logic [7:0]                    msg_type_reg, msg_type_next;
    logic [15:0]                   rec_count_reg, rec_count_next;
    logic [15:0]                   ones_sum_reg, ones_sum_next;
    logic [7:0]                    pending_reg, pending_next;

    logic [3:0]                    ihl;
    logic                          in_payload;
    logic [igmpc_pkg::COUNT_W-1:0] off;
    logic [15:0]                   add_word;
    logic [16:0]                   raw_sum;
    logic                          do_add;

    always_comb begin
        ihl = (word.data_byte[3:0] < 4'd5) ? 4'd5 : word.data_byte[3:0];

        in_payload = (byte_count_reg >= igmpc_pkg::POS_PAYLOAD)
                  && (byte_count_reg >= {6'd0, header_bytes_reg})
                  && (byte_count_reg < igmpc_pkg::COUNT_SAT);
        off = byte_count_reg - {6'd0, header_bytes_reg};

        header_bytes_next = header_bytes_reg;
        is_igmp_next      = is_igmp_reg;
        msg_type_next     = msg_type_reg;
        rec_count_next    = rec_count_reg;
        pending_next      = pending_reg;
        add_word          = 16'd0;
        do_add            = 1'b0;

        if (byte_count_reg == '0) begin
            header_bytes_next = {ihl, 2'b00};
        end
        if (byte_count_reg == igmpc_pkg::POS_PROTO) begin
            is_igmp_next = (word.data_byte == igmpc_pkg::IGMP_PROTO);
        end
        if (in_payload) begin
            if (off == '0) begin
                msg_type_next = word.data_byte;
            end
            if (off == igmpc_pkg::OFF_COUNT_HI) begin
                rec_count_next[15:8] = word.data_byte;
            end
            if (off == igmpc_pkg::OFF_COUNT_LO) begin
                rec_count_next[7:0] = word.data_byte;
            end
            if (!off[0]) begin
                // high byte of a word, summed now only if the packet ends here
                pending_next = word.data_byte;
                add_word     = {word.data_byte, 8'd0};
                do_add       = word.last;
            end else begin
                add_word = {pending_reg, word.data_byte};
                do_add   = 1'b1;
            end
        end

        // end-around carry
        raw_sum       = {1'b0, ones_sum_reg} + {1'b0, add_word};
        ones_sum_next = do_add ? (raw_sum[15:0] + {15'd0, raw_sum[16]}) : ones_sum_reg;

        byte_count_next = (byte_count_reg < igmpc_pkg::COUNT_SAT)
                        ? byte_count_reg + 12'd1 : byte_count_reg;
    end

    always_comb begin
        summary.total        = {1'b0, byte_count_reg} + 13'd1;
        summary.header_bytes = header_bytes_next;
        summary.is_igmp      = is_igmp_next;
        summary.msg_type     = msg_type_next;
        summary.rec_count    = rec_count_next;
        summary.ones_sum     = ones_sum_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (consume && word.last)) begin
            byte_count_reg   <= '0;
            header_bytes_reg <= '0;
            is_igmp_reg      <= 1'b0;
            msg_type_reg     <= '0;
            rec_count_reg    <= '0;
            ones_sum_reg     <= '0;
            pending_reg      <= '0;
        end else if (consume) begin
            byte_count_reg   <= byte_count_next;
            header_bytes_reg <= header_bytes_next;
            is_igmp_reg      <= is_igmp_next;
            msg_type_reg     <= msg_type_next;
            rec_count_reg    <= rec_count_next;
            ones_sum_reg     <= ones_sum_next;
            pending_reg      <= pending_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/igmpc_judge.sv
// ---------------------------------------------------------------------------
// igmpc_judge
// verdict rules and the result register
// ---------------------------------------------------------------------------
`default_nettype none

module igmpc_judge (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     finish,
    input  wire igmpc_pkg::pkt_summary_t  summary,
    output logic                          out_free,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output igmpc_pkg::out_word_t          m_data
);

    logic [2:0]                    code;
    logic [igmpc_pkg::TOTAL_W-1:0] hb_ext;
    logic [igmpc_pkg::TOTAL_W-1:0] payload;
    logic [igmpc_pkg::LIMIT_W-1:0] limit;
    logic                          is_query;
    logic                          is_report;

    logic                 m_valid_reg, m_valid_next;
    igmpc_pkg::out_word_t m_word_reg;

    always_comb begin
        hb_ext    = {{(igmpc_pkg::TOTAL_W-igmpc_pkg::HDR_W){1'b0}}, summary.header_bytes};
        payload   = summary.total - hb_ext;
        is_query  = (summary.msg_type == igmpc_pkg::TYPE_QUERY);
        is_report = (summary.msg_type == igmpc_pkg::TYPE_REPORT);
        limit = is_query
              ? igmpc_pkg::LIMIT_W'(igmpc_pkg::QUERY_BYTES)
              : igmpc_pkg::LIMIT_W'(igmpc_pkg::REPORT_HEADER_BYTES)
                + igmpc_pkg::LIMIT_W'(summary.rec_count)
                * igmpc_pkg::LIMIT_W'(igmpc_pkg::RECORD_BYTES);

        priority if (summary.total < 13'd10) begin
            code = igmpc_pkg::VERDICT_TRUNCATED;
        end else if (!summary.is_igmp) begin
            code = igmpc_pkg::VERDICT_NOT_IGMP;
        end else if (summary.total <= hb_ext) begin
            code = igmpc_pkg::VERDICT_TRUNCATED;
        end else if (!is_query && !is_report) begin
            code = igmpc_pkg::VERDICT_BAD_TYPE;
        end else if (is_report && (summary.total < hb_ext + 13'd8)) begin
            code = igmpc_pkg::VERDICT_TRUNCATED;
        end else if ((summary.total > igmpc_pkg::TOTAL_W'(igmpc_pkg::MAX_PACKET_BYTES))
                  || summary.total[igmpc_pkg::TOTAL_W-1]) begin
            code = igmpc_pkg::VERDICT_TOO_LONG;
        end else if (igmpc_pkg::LIMIT_W'(payload) > limit) begin
            code = igmpc_pkg::VERDICT_TOO_LONG;
        end else if (summary.ones_sum != 16'hFFFF) begin
            code = igmpc_pkg::VERDICT_BAD_CSUM;
        end else begin
            code = igmpc_pkg::VERDICT_OK;
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (finish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            m_word_reg.accept       <= (code == igmpc_pkg::VERDICT_OK);
            m_word_reg.verdict_code <= code;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_word_reg;

endmodule

`default_nettype wire

FILE: rtl/core/igmp_header_checker.sv
// ---------------------------------------------------------------------------
// igmp_header_checker
// byte-stream igmpv3 header and payload checksum checker
// ---------------------------------------------------------------------------
// takes an ipv4 packet one byte per word, starting at the ip header, with
// last set on the final byte, and gives one verdict word per packet: accept
// and a verdict code (ok, not igmp, unknown type, too long, bad checksum,
// truncated). the block takes one byte every cycle, with no gap between
// packets, save where a last byte is held back as below; each byte goes
// through an input register, then the header parser and ones' complement
// accumulator update their state at the next clock edge, and on the last
// byte the verdict is written to the result register at that same edge, from
// which it is offered. the per-cycle work is one 16-bit end-around-carry add
// plus the length compares of the verdict rules. while a verdict waits on
// m_ready, bytes of the next packet keep flowing; only a second last byte
// stalls the input until the waiting verdict is taken
// ---------------------------------------------------------------------------
`default_nettype none

module igmp_header_checker (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire igmpc_pkg::in_word_t  s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output igmpc_pkg::out_word_t      m_data
);

    logic                    word_valid;
    igmpc_pkg::in_word_t     word;
    logic                    consume;
    logic                    out_free;
    igmpc_pkg::pkt_summary_t summary;

    // a byte leaves the input register unless it ends a packet and the
    // result register still holds an untaken verdict
    assign consume = word_valid && (!word.last || out_free);

    igmpc_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .consume    (consume),
        .word_valid (word_valid),
        .word       (word)
    );

    // header fields and payload sum, cleared after each last byte
    igmpc_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .consume (consume),
        .word    (word),
        .summary (summary)
    );

    // verdict rules in priority order and the output register
    igmpc_judge u_judge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .finish   (consume && word.last),
        .summary  (summary),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// self-checking bench for the igmp header checker
// ---------------------------------------------------------------------------
// feeds ipv4 packets one byte per word and checks every verdict word against
// a typed-in or tracked verdict. a short table of hand-picked packets comes
// first: extremes, every verdict code, short and long header lengths, odd
// payloads, over-limit payloads and the largest record count. random packets
// follow in three idling phases, mostly well-formed igmp with random content
// plus noise and cut-off packets
// ---------------------------------------------------------------------------

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    // ipv4 header length floor, igmp checksum offset, drain guard and phase size
    localparam logic [3:0] MIN_IHL     = 4'd5;
    localparam int         CSUM_OFF    = 2;
    localparam int         DRAIN_LIMIT = 2000;
    localparam int         PHASE_BYTES = 50;

    // idling per phase, percent of cycles: sender then receiver
    localparam int SEND_IDLE [3] = '{21, 74, 0};
    localparam int RECV_IDLE [3] = '{74, 21, 0};

    typedef enum logic {ROW_RAW, ROW_IGMP} row_kind_t;

    // one directed packet: raw filler bytes, or a built igmp packet whose
    // len is the payload length after the ip header
    typedef struct packed {
        row_kind_t   kind;
        bit          rand_fill;
        logic [7:0]  fill_byte;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [7:0]  mtype;
        logic [15:0] records;
        int          len;
        bit          good_csum;
        bit          typed;
        logic [2:0]  verdict;
    } stim_row_t;

    logic                 aclk;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    igmpc_pkg::in_word_t  s_data  = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    igmpc_pkg::out_word_t m_data;

    igmp_header_checker u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 250 MHz
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #2ms;
        $display("igmp_header_checker: mismatch");
        $finish;
    end

    // -----------------------------------------------------------------------
    // packet tracker: mirrors the checker's per-packet state
    // -----------------------------------------------------------------------
    logic [11:0] pk_count   = '0;
    logic [5:0]  pk_hdr_len = '0;
    logic        pk_is_igmp = 1'b0;
    logic [7:0]  pk_type    = '0;
    logic [15:0] pk_records = '0;
    logic [15:0] pk_sum     = '0;
    logic [7:0]  pk_high    = '0;

    igmpc_pkg::out_word_t pending_verdicts [$];
    int                   table_verdicts [$];   // typed-in verdicts, -1 = track
    logic [7:0]           frame [$];            // packet being sent

    int mismatches   = 0;
    int bytes_sent   = 0;
    int packets_sent = 0;
    int verdicts_ok  = 0;
    int verdict_tally [8];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    task automatic flag_mismatch(input string what);
        $display("%t  error: %s", $realtime, what);
        mismatches++;
    endtask

    // end-around-carry add of one 16-bit word
    function automatic logic [15:0] fold_add(input logic [15:0] acc, input logic [15:0] w);
        logic [16:0] s;
        s = {1'b0, acc} + {1'b0, w};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // verdict for a packet of total bytes, first failing rule wins
    function automatic logic [2:0] grade_packet(input int total);
        int payload;
        int allowed;
        if (total < 10)
            return igmpc_pkg::VERDICT_TRUNCATED;
        if (!pk_is_igmp)
            return igmpc_pkg::VERDICT_NOT_IGMP;
        if (total < pk_hdr_len + 1)
            return igmpc_pkg::VERDICT_TRUNCATED;
        if (pk_type != igmpc_pkg::TYPE_QUERY && pk_type != igmpc_pkg::TYPE_REPORT)
            return igmpc_pkg::VERDICT_BAD_TYPE;
        if (pk_type == igmpc_pkg::TYPE_REPORT && total < pk_hdr_len + 8)
            return igmpc_pkg::VERDICT_TRUNCATED;
        if (total > igmpc_pkg::MAX_PACKET_BYTES || total > igmpc_pkg::COUNT_SAT)
            return igmpc_pkg::VERDICT_TOO_LONG;
        payload = total - pk_hdr_len;
        if (pk_type == igmpc_pkg::TYPE_QUERY)
            allowed = igmpc_pkg::QUERY_BYTES;
        else
            allowed = igmpc_pkg::REPORT_HEADER_BYTES + pk_records * igmpc_pkg::RECORD_BYTES;
        if (payload > allowed)
            return igmpc_pkg::VERDICT_TOO_LONG;
        if (pk_sum != 16'hFFFF)
            return igmpc_pkg::VERDICT_BAD_CSUM;
        return igmpc_pkg::VERDICT_OK;
    endfunction

    task automatic track_byte(input igmpc_pkg::in_word_t w);
        int                   pos;
        int                   off;
        int                   typed;
        logic [3:0]           ihl;
        logic [2:0]           code;
        igmpc_pkg::out_word_t verdict;
        pos = pk_count;
        if (pos == 0) begin
            ihl = w.data_byte[3:0];
            if (ihl < MIN_IHL)
                ihl = MIN_IHL;
            pk_hdr_len = {ihl, 2'b00};
        end
        if (pos == igmpc_pkg::POS_PROTO)
            pk_is_igmp = (w.data_byte == igmpc_pkg::IGMP_PROTO);
        // payload bytes: type, record count and checksum words
        if (pos >= igmpc_pkg::POS_PAYLOAD && pos >= pk_hdr_len
                && pos < igmpc_pkg::COUNT_SAT) begin
            off = pos - pk_hdr_len;
            if (off == 0)
                pk_type = w.data_byte;
            if (off == igmpc_pkg::OFF_COUNT_HI)
                pk_records[15:8] = w.data_byte;
            if (off == igmpc_pkg::OFF_COUNT_LO)
                pk_records[7:0] = w.data_byte;
            if (off[0] == 1'b0) begin
                pk_high = w.data_byte;
                // a lone final byte is the high half of a zero-padded word
                if (w.last)
                    pk_sum = fold_add(pk_sum, {w.data_byte, 8'h00});
            end else begin
                pk_sum = fold_add(pk_sum, {pk_high, w.data_byte});
            end
        end
        if (pk_count != igmpc_pkg::COUNT_SAT)
            pk_count++;
        if (w.last) begin
            code = grade_packet(pos + 1);
            if (table_verdicts.size() != 0) begin
                typed = table_verdicts.pop_front();
                if (typed >= 0)
                    code = 3'(typed);
            end
            verdict.accept       = (code == igmpc_pkg::VERDICT_OK);
            verdict.verdict_code = code;
            pending_verdicts.push_back(verdict);
            pk_count   = '0;
            pk_hdr_len = '0;
            pk_is_igmp = 1'b0;
            pk_type    = '0;
            pk_records = '0;
            pk_sum     = '0;
            pk_high    = '0;
        end
    endtask

    // -----------------------------------------------------------------------
    // monitors: both sample the pre-edge values of the handshake
    // -----------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            track_byte(s_data);
    end

    always @(posedge aclk) begin
        igmpc_pkg::out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_verdicts.size() == 0) begin
                flag_mismatch($sformatf("verdict word with none expected: accept %b code %0d",
                                        m_data.accept, m_data.verdict_code));
            end else begin
                want = pending_verdicts.pop_front();
                if (m_data.accept !== want.accept)
                    flag_mismatch($sformatf("accept %b, expected %b (code %0d)",
                                            m_data.accept, want.accept, want.verdict_code));
                if (m_data.verdict_code !== want.verdict_code)
                    flag_mismatch($sformatf("verdict code %0d, expected %0d",
                                            m_data.verdict_code, want.verdict_code));
                verdict_tally[want.verdict_code]++;
                verdicts_ok++;
            end
        end
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= recv_idle_pct);

    // -----------------------------------------------------------------------
    // packet building and driving
    // -----------------------------------------------------------------------

    // ipv4 header plus igmp payload; when the payload holds the checksum field,
    // it is fixed so that the payload folds to all ones, or broken by one bit
    task automatic build_igmp(input logic [3:0] ihl, input logic [7:0] proto,
                              input logic [7:0] mtype, input logic [15:0] records,
                              input int pay_len, input bit good_csum);
        int          hdr;
        int          i;
        logic [7:0]  b;
        logic [15:0] s;
        hdr = 4 * ((ihl < MIN_IHL) ? MIN_IHL : ihl);
        frame.delete();
        frame.push_back({4'h4, ihl});
        for (i = 1; i < hdr; i++)
            frame.push_back((i == igmpc_pkg::POS_PROTO) ? proto : 8'($urandom));
        for (i = 0; i < pay_len; i++) begin
            if (i == 0)
                b = mtype;
            else if (i == CSUM_OFF || i == CSUM_OFF + 1)
                b = 8'h00;
            else if (i == igmpc_pkg::OFF_COUNT_HI)
                b = records[15:8];
            else if (i == igmpc_pkg::OFF_COUNT_LO)
                b = records[7:0];
            else
                b = 8'($urandom);
            frame.push_back(b);
        end
        if (pay_len >= CSUM_OFF + 2) begin
            s = '0;
            for (i = 0; i < pay_len; i += 2)
                s = fold_add(s, {frame[hdr+i], (i + 1 < pay_len) ? frame[hdr+i+1] : 8'h00});
            s = ~s;
            if (!good_csum)
                s = s ^ (16'h1 << $urandom_range(15));
            frame[hdr+CSUM_OFF]   = s[15:8];
            frame[hdr+CSUM_OFF+1] = s[7:0];
        end
    endtask

    // mostly well-formed igmp, some noise, some packets cut short
    task automatic random_frame();
        int          pick;
        int          pay;
        int          cut;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [7:0]  mtype;
        logic [15:0] recs;
        pick = $urandom_range(99);
        if (pick < 12) begin
            frame.delete();
            repeat ($urandom_range(1, 40))
                frame.push_back(8'($urandom));
            return;
        end
        ihl   = ($urandom_range(3) == 0) ? 4'($urandom) : MIN_IHL;
        proto = ($urandom_range(19) == 0) ? 8'($urandom) : igmpc_pkg::IGMP_PROTO;
        case ($urandom_range(9))
            0:             mtype = 8'($urandom);
            1, 2, 3, 4, 5: mtype = igmpc_pkg::TYPE_QUERY;
            default:       mtype = igmpc_pkg::TYPE_REPORT;
        endcase
        recs = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(3));
        if (mtype == igmpc_pkg::TYPE_QUERY)
            pay = $urandom_range(8, igmpc_pkg::QUERY_BYTES);
        else if (mtype == igmpc_pkg::TYPE_REPORT)
            pay = igmpc_pkg::REPORT_HEADER_BYTES
                + ((recs > 3) ? $urandom_range(3) : recs) * igmpc_pkg::RECORD_BYTES;
        else
            pay = $urandom_range(1, 16);
        // wrong payload length now and then
        if ($urandom_range(9) == 0)
            pay = $urandom_range(0, pay + 8);
        build_igmp(ihl, proto, mtype, recs, pay, $urandom_range(9) != 0);
        if (pick < 22) begin
            cut = $urandom_range(1, frame.size());
            while (frame.size() > cut)
                void'(frame.pop_back());
        end
    endtask

    // one word on the input channel; returns in the step after acceptance
    task automatic send_word(input igmpc_pkg::in_word_t w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_frame();
        int                  n;
        igmpc_pkg::in_word_t w;
        n = frame.size();
        for (int i = 0; i < n; i++) begin
            w.data_byte = frame[i];
            w.last      = (i == n - 1);
            send_word(w);
        end
        packets_sent++;
    endtask

    // sender holds off until every verdict so far has been taken
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        do
            @(posedge aclk);
        while (pending_verdicts.size() != 0);
    endtask

    // -----------------------------------------------------------------------
    // directed packets; verdict typed in where it is plain, else tracked
    // -----------------------------------------------------------------------
    stim_row_t directed_rows [20] = '{
        // single byte, and ending before the protocol byte
        '{ROW_RAW,  1'b1, 8'h00, 4'd0, 8'h00, 8'h00,
          16'h0000, 1, 1'b0, 1'b1, igmpc_pkg::VERDICT_TRUNCATED},
        '{ROW_RAW,  1'b1, 8'h00, 4'd0, 8'h00, 8'h00,
          16'h0000, 9, 1'b0, 1'b1, igmpc_pkg::VERDICT_TRUNCATED},
        // all-zero and all-ones bytes
        '{ROW_RAW,  1'b0, 8'h00, 4'd0, 8'h00, 8'h00,
          16'h0000, 20, 1'b0, 1'b1, igmpc_pkg::VERDICT_NOT_IGMP},
        '{ROW_RAW,  1'b0, 8'hFF, 4'd0, 8'h00, 8'h00,
          16'h0000, 20, 1'b0, 1'b1, igmpc_pkg::VERDICT_NOT_IGMP},
        // protocol other than igmp
        '{ROW_IGMP, 1'b0, 8'h00, 4'd5, 8'd6, igmpc_pkg::TYPE_QUERY,
          16'h0000, 12, 1'b1, 1'b1, igmpc_pkg::VERDICT_NOT_IGMP},
        // ends at the last header byte, before the type
        '{ROW_IGMP, 1'b0, 8'h00, 4'd5, igmpc_pkg::IGMP_PROTO, igmpc_pkg::TYPE_QUERY,
          16'h0000, 0, 1'b1, 1'b1, igmpc_pkg::VERDICT_TRUNCATED},
        // unknown type (v2 report)
        '{ROW_IGMP, 1'b0, 8'h00, 4'd5, igmpc_pkg::IGMP_PROTO, 8'h16,
          16'h0000, 8, 1'b1, 1'b1, igmpc_pkg::VERDICT_BAD_TYPE},
        // report ending inside its record count
        '{ROW_IGMP, 1'b0, 8'h00, 4'd5, igmpc_pkg::IGMP_PROTO, igmpc_pkg::TYPE_REPORT,
          16'h0000, 7, 1'b1, 1'b1, igmpc_pkg::VERDICT_TRUNCATED},
        // query at its size limit and one past
        '{ROW_IGMP, 1'b0, 8'h00, 4'd5, igmpc_pkg::IGMP_PROTO, igmpc_pkg::TYPE_QUERY,
          16'h0000, 12, 1'b1, 1'b1, igmpc_pkg::VERDICT_OK},
        '{ROW_IGMP, 1'b0, 8'h00, 4'd5, igmpc_pkg::IGMP_PROTO, igmpc_pkg::TYPE_QUERY,
          16'h0000, 13, 1'b1, 1'b1, igmpc_pkg::VERDICT_TOO_LONG},
        // report with two records, exact and one byte over
        '{ROW_IGMP, 1'b0, 8'h00, 4'd5, igmpc_pkg::IGMP_PROTO, igmpc_pkg::TYPE_REPORT,
          16'h0002, 24, 1'b1, 1'b1, igmpc_pkg::VERDICT_OK},
        '{ROW_IGMP, 1'b0, 8'h00, 4'd5, igmpc_pkg::IGMP_PROTO, igmpc_pkg::TYPE_REPORT,
          16'h0002, 25, 1'b1, 1'b1, igmpc_pkg::VERDICT_TOO_LONG},
        // broken checksum
        '{ROW_IGMP, 1'b0, 8'h00, 4'd5, igmpc_pkg::IGMP_PROTO, igmpc_pkg::TYPE_REPORT,
          16'h0000, 8, 1'b0, 1'b1, igmpc_pkg::VERDICT_BAD_CSUM},
        // header length below five words counts as five
        '{ROW_IGMP, 1'b0, 8'h00, 4'd2, igmpc_pkg::IGMP_PROTO, igmpc_pkg::TYPE_QUERY,
          16'h0000, 8, 1'b1, 1'b1, igmpc_pkg::VERDICT_OK},
        // largest header length
        '{ROW_IGMP, 1'b0, 8'h00, 4'd15, igmpc_pkg::IGMP_PROTO, igmpc_pkg::TYPE_QUERY,
          16'h0000, 12, 1'b1, 1'b1, igmpc_pkg::VERDICT_OK},
        '{ROW_IGMP, 1'b0, 8'h00, 4'd15, igmpc_pkg::IGMP_PROTO, igmpc_pkg::TYPE_REPORT,
          16'h0001, 16, 1'b1, 1'b1, igmpc_pkg::VERDICT_OK},
        // odd payload length, lone byte padded
        '{ROW_IGMP, 1'b0, 8'h00, 4'd5, igmpc_pkg::IGMP_PROTO, igmpc_pkg::TYPE_QUERY,
          16'h0000, 9, 1'b1, 1'b1, igmpc_pkg::VERDICT_OK},
        '{ROW_IGMP, 1'b0, 8'h00, 4'd5, igmpc_pkg::IGMP_PROTO, igmpc_pkg::TYPE_REPORT,
          16'h0003, 31, 1'b0, 1'b0, igmpc_pkg::VERDICT_OK},
        // type byte alone
        '{ROW_IGMP, 1'b0, 8'h00, 4'd5, igmpc_pkg::IGMP_PROTO, igmpc_pkg::TYPE_QUERY,
          16'h0000, 1, 1'b1, 1'b0, igmpc_pkg::VERDICT_OK},
        // largest record count, short report well inside its limit
        '{ROW_IGMP, 1'b0, 8'h00, 4'd5, igmpc_pkg::IGMP_PROTO, igmpc_pkg::TYPE_REPORT,
          16'hFFFF, 24, 1'b1, 1'b1, igmpc_pkg::VERDICT_OK}
    };

    // -----------------------------------------------------------------------
    // main sequence
    // -----------------------------------------------------------------------
    initial begin
        int start_bytes;
        int guard;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed packets run under the first idling pattern
        send_idle_pct = SEND_IDLE[0];
        recv_idle_pct = RECV_IDLE[0];
        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_RAW) begin
                frame.delete();
                repeat (directed_rows[r].len)
                    frame.push_back(directed_rows[r].rand_fill ? 8'($urandom)
                                                               : directed_rows[r].fill_byte);
            end else begin
                build_igmp(directed_rows[r].ihl, directed_rows[r].proto,
                           directed_rows[r].mtype, directed_rows[r].records,
                           directed_rows[r].len, directed_rows[r].good_csum);
            end
            table_verdicts.push_back(directed_rows[r].typed ? int'(directed_rows[r].verdict)
                                                            : -1);
            send_frame();
        end

        // random packets: slow receiver, then slow sender, then full rate;
        // the sender drains the checker before each phase
        for (int phase = 0; phase < 3; phase++) begin
            hold_until_drained();
            send_idle_pct = SEND_IDLE[phase];
            recv_idle_pct = RECV_IDLE[phase];
            start_bytes   = bytes_sent;
            while (bytes_sent - start_bytes < PHASE_BYTES) begin
                random_frame();
                send_frame();
            end
        end
        s_valid <= 1'b0;

        // drain, then idle cycles for any stray verdict word
        guard = 0;
        while (pending_verdicts.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        repeat (8) @(posedge aclk);
        if (pending_verdicts.size() != 0)
            flag_mismatch($sformatf("%0d verdict words never arrived", pending_verdicts.size()));

        $display("run covered %0d packets in %0d bytes, %0d verdict words checked",
                 packets_sent, bytes_sent, verdicts_ok);
        $display({"verdicts: ok %0d, not igmp %0d, bad type %0d, too long %0d, ",
                  "bad csum %0d, truncated %0d"},
                 verdict_tally[igmpc_pkg::VERDICT_OK],
                 verdict_tally[igmpc_pkg::VERDICT_NOT_IGMP],
                 verdict_tally[igmpc_pkg::VERDICT_BAD_TYPE],
                 verdict_tally[igmpc_pkg::VERDICT_TOO_LONG],
                 verdict_tally[igmpc_pkg::VERDICT_BAD_CSUM],
                 verdict_tally[igmpc_pkg::VERDICT_TRUNCATED]);
        if (mismatches == 0)
            $display("igmp_header_checker: match");
        else
            $display("igmp_header_checker: mismatch");
        $finish;
    end

endmodule
